// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication; disabled while rst_n is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication; disabled while rst_n is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cpu8a_pkg.sv
// Package: types, codes and flag helpers of the 8-bit arithmetic unit.
`default_nettype none
package cpu8a_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_ADC = 4'd1,
        OP_ADI = 4'd2,
        OP_ACI = 4'd3,
        OP_SUB = 4'd4,
        OP_SBB = 4'd5,
        OP_SUI = 4'd6,
        OP_SBI = 4'd7,
        OP_INR = 4'd8,
        OP_DCR = 4'd9,
        OP_INX = 4'd10,
        OP_DCX = 4'd11,
        OP_DAD = 4'd12,
        OP_CMA = 4'd13
    } t_op;

    // register file slots
    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_L = 3'd5;
    localparam logic [2:0] REG_A = 3'd6;

    // reg_sel codes that are not a plain slot
    localparam logic [2:0] SEL_MEM = 3'd6;
    localparam logic [2:0] SEL_A   = 3'd7;

    localparam logic [1:0] PAIR_NONE = 2'd3;

    // flag bit positions
    localparam int F_S  = 4;
    localparam int F_Z  = 3;
    localparam int F_AC = 2;
    localparam int F_P  = 1;
    localparam int F_CY = 0;

    localparam int NUM_REGS   = 7;
    localparam int STATE_DEPTH = 1;

    typedef struct packed {
        logic [4:0]                flags;
        logic [NUM_REGS-1:0][7:0]  regs;
    } t_arch_state;

    localparam int STATE_W = $bits(t_arch_state);

    typedef struct packed {
        logic [3:0] req_type;
        logic [2:0] reg_sel;
        logic [1:0] pair_sel;
        logic [7:0] imm;
        logic [7:0] mem_data;
    } t_item;

    typedef struct packed {
        logic [7:0]  acc;
        logic [4:0]  flags;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_write_data;
    } t_result;

    // S, Z, P from an 8-bit result plus given AC and CY
    function automatic logic [4:0] szp(input logic [7:0] r, input logic ac, input logic cy);
        logic [4:0] f;
        f       = '0;
        f[F_S]  = r[7];
        f[F_Z]  = (r == 8'd0);
        f[F_AC] = ac;
        f[F_P]  = ~^r;
        f[F_CY] = cy;
        return f;
    endfunction

endpackage
`default_nettype wire

// File: hdl/cpu8a_if.sv
// Valid/ready channel interfaces for the request and result items.
`default_nettype none
interface cpu8a_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] req_type;
    logic [2:0] reg_sel;
    logic [1:0] pair_sel;
    logic [7:0] imm;
    logic [7:0] mem_data;

    modport source (output valid, req_type, reg_sel, pair_sel, imm, mem_data, input ready);
    modport sink   (input valid, req_type, reg_sel, pair_sel, imm, mem_data, output ready);
endinterface

interface cpu8a_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  acc;
    logic        sign_flag;
    logic        zero_flag;
    logic        aux_flag;
    logic        parity_flag;
    logic        carry_flag;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;

    modport source (output valid, acc, sign_flag, zero_flag, aux_flag, parity_flag,
                    carry_flag, mem_write, mem_address, mem_write_data, input ready);
    modport sink   (input valid, acc, sign_flag, zero_flag, aux_flag, parity_flag,
                    carry_flag, mem_write, mem_address, mem_write_data, output ready);
endinterface
`default_nettype wire

// File: hdl/cpu8a_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpu8a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: hdl/cpu8a_exec.sv
// Execute stage: applies one instruction to the architectural state.
`default_nettype none
module cpu8a_exec (
    input  wire cpu8a_pkg::t_item       i_item,
    input  wire cpu8a_pkg::t_arch_state i_state,
    output cpu8a_pkg::t_arch_state      o_state,
    output cpu8a_pkg::t_result          o_res
);
    import cpu8a_pkg::*;

    always_comb begin
        t_arch_state st;
        logic [7:0]  a;
        logic        cyin;
        logic [15:0] hl;
        logic [2:0]  src_idx;
        logic [7:0]  src;
        logic        use_imm;
        logic [7:0]  opnd;
        logic        cin;
        logic [8:0]  sum;
        logic [4:0]  aux_s;
        logic [8:0]  dif;
        logic [4:0]  aux_d;
        logic [7:0]  r;
        logic        r_ac;
        logic        pair_ok;
        logic [2:0]  phi;
        logic [2:0]  plo;
        logic [15:0] pv;
        logic [15:0] pn;
        logic [16:0] dad;
        logic        mw;
        logic [7:0]  mwd;

        st      = i_state;
        mw      = 1'b0;
        mwd     = 8'd0;
        a       = i_state.regs[REG_A];
        cyin    = i_state.flags[F_CY];
        hl      = {i_state.regs[REG_H], i_state.regs[REG_L]};
        src_idx = (i_item.reg_sel == SEL_A) ? REG_A : i_item.reg_sel;
        src     = (i_item.reg_sel == SEL_MEM) ? i_item.mem_data : i_state.regs[src_idx];
        use_imm = i_item.req_type inside {OP_ADI, OP_ACI, OP_SUI, OP_SBI};
        opnd    = use_imm ? i_item.imm : src;
        // odd codes of the add/sub group take carry (borrow) in
        cin     = i_item.req_type[0] & cyin;

        sum   = {1'b0, a} + {1'b0, opnd} + {8'd0, cin};
        aux_s = {1'b0, a[3:0]} + {1'b0, opnd[3:0]} + {4'd0, cin};
        dif   = {1'b0, a} - {1'b0, opnd} - {8'd0, cin};
        aux_d = {1'b0, a[3:0]} - {1'b0, opnd[3:0]} - {4'd0, cin};

        if (i_item.req_type == OP_INR) begin
            r    = src + 8'd1;
            r_ac = (src[3:0] == 4'hF);
        end else begin
            r    = src - 8'd1;
            r_ac = (src[3:0] == 4'h0);
        end

        pair_ok = (i_item.pair_sel != PAIR_NONE);
        phi     = pair_ok ? {i_item.pair_sel, 1'b0} : REG_B;
        plo     = pair_ok ? {i_item.pair_sel, 1'b1} : REG_C;
        pv      = {i_state.regs[phi], i_state.regs[plo]};
        pn      = (i_item.req_type == OP_INX) ? pv + 16'd1 : pv - 16'd1;
        dad     = {1'b0, hl} + {1'b0, pv};

        case (i_item.req_type)
            OP_ADD, OP_ADC, OP_ADI, OP_ACI: begin
                st.regs[REG_A] = sum[7:0];
                st.flags       = szp(sum[7:0], aux_s[4], sum[8]);
            end
            OP_SUB, OP_SBB, OP_SUI, OP_SBI: begin
                st.regs[REG_A] = dif[7:0];
                st.flags       = szp(dif[7:0], aux_d[4], dif[8]);
            end
            OP_INR, OP_DCR: begin
                if (i_item.reg_sel == SEL_MEM) begin
                    mw  = 1'b1;
                    mwd = r;
                end else begin
                    st.regs[src_idx] = r;
                end
                st.flags = szp(r, r_ac, cyin);
            end
            OP_INX, OP_DCX: begin
                if (pair_ok) begin
                    st.regs[phi] = pn[15:8];
                    st.regs[plo] = pn[7:0];
                end
            end
            OP_DAD: begin
                if (pair_ok) begin
                    st.regs[REG_H]  = dad[15:8];
                    st.regs[REG_L]  = dad[7:0];
                    st.flags[F_CY]  = dad[16];
                end
            end
            OP_CMA: begin
                st.regs[REG_A] = ~a;
            end
            default: begin
            end
        endcase

        o_state              = st;
        o_res.acc            = st.regs[REG_A];
        o_res.flags          = st.flags;
        o_res.mem_write      = mw;
        o_res.mem_address    = hl;
        o_res.mem_write_data = mwd;
    end
endmodule
`default_nettype wire

// File: hdl/cpu8_arith_instruction_unit.sv
// Top level: 8-bit CPU arithmetic instruction unit.
//
// Usage:
//   i_req  - one instruction per item: req_type, reg_sel, pair_sel, imm and
//            mem_data (the byte at HL, used when reg_sel selects memory).
//   o_rsp  - one result per instruction: A and flags after the instruction,
//            memory write request (INR M / DCR M) and the HL address seen
//            before the instruction.
// Pipeline: the accept edge does the state RAM read and item capture; the
//   execute stage then writes its result into the output register.
// Throughput: 1 item per cycle while o_rsp takes results. Registers B..L, A
//   and the flags live in one wide state word of a synchronous RAM; each item
//   reads it on accept and writes it back as it leaves the execute stage. A
//   back-to-back item forwards the word being written, so no bubble is needed.
// Reset: synchronous, active low. Registers and flags read as zero until the
//   first write back; no clearing pass is needed.
// Stall: when o_rsp is held off, the result waits in the output register, one
//   more item may wait in the execute stage, then i_req.ready drops.
`default_nettype none
module cpu8_arith_instruction_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpu8a_in_if.sink   i_req,
    cpu8a_out_if.source o_rsp
);
    import cpu8a_pkg::*;

    // execute stage
    logic        r_s1_valid;
    t_item       r_s1_item;
    // forwarding and not-yet-written tracking of the state word
    logic        r_init;
    logic        r_rd_init;
    logic        r_fwd_use;
    t_arch_state r_fwd_state;
    // output register
    logic        r_out_valid;
    t_result     r_out;

    logic                in_acc;
    logic                s1_go;
    logic                s1_fire;
    logic [STATE_W-1:0]  ram_q;
    t_arch_state         cur_state;
    t_arch_state         nxt_state;
    t_result             res;
    t_item               in_item;

    assign s1_go   = !r_out_valid || o_rsp.ready;
    assign s1_fire = r_s1_valid && s1_go;
    assign i_req.ready = !r_s1_valid || s1_go;
    assign in_acc  = i_req.valid && i_req.ready;

    assign in_item.req_type = i_req.req_type;
    assign in_item.reg_sel  = i_req.reg_sel;
    assign in_item.pair_sel = i_req.pair_sel;
    assign in_item.imm      = i_req.imm;
    assign in_item.mem_data = i_req.mem_data;

    cpu8a_ram #(
        .WIDTH(STATE_W),
        .DEPTH(STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (1'b0),
        .i_wdata (nxt_state),
        .i_re    (in_acc),
        .i_raddr (1'b0),
        .o_rdata (ram_q)
    );

    // state seen by the execute stage: forwarded write, RAM word, or reset value
    always_comb begin
        if (r_fwd_use) begin
            cur_state = r_fwd_state;
        end else if (r_rd_init) begin
            cur_state = t_arch_state'(ram_q);
        end else begin
            cur_state = '0;
        end
    end

    cpu8a_exec u_exec (
        .i_item  (r_s1_item),
        .i_state (cur_state),
        .o_state (nxt_state),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_init      <= 1'b0;
            r_rd_init   <= 1'b0;
            r_fwd_use   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_rd_init  <= r_init;
                // read collides with this cycle's write back
                r_fwd_use  <= s1_fire;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_init <= 1'b1;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= in_item;
        end
        if (in_acc && s1_fire) begin
            r_fwd_state <= nxt_state;
        end
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.acc            = r_out.acc;
    assign o_rsp.sign_flag      = r_out.flags[F_S];
    assign o_rsp.zero_flag      = r_out.flags[F_Z];
    assign o_rsp.aux_flag       = r_out.flags[F_AC];
    assign o_rsp.parity_flag    = r_out.flags[F_P];
    assign o_rsp.carry_flag     = r_out.flags[F_CY];
    assign o_rsp.mem_write      = r_out.mem_write;
    assign o_rsp.mem_address    = r_out.mem_address;
    assign o_rsp.mem_write_data = r_out.mem_write_data;
endmodule
`default_nettype wire

// File: hdl/cpu8a_checker.sv
// Port-level checker of the arithmetic unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cpu8a_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_out_acc,
    input wire logic [15:0] i_out_mem_address,
    input wire logic        i_out_mem_write,
    input wire logic [7:0]  i_out_mem_write_data
);
    // a result held off by the sink stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_acc) && $stable(i_out_mem_address), "result changed while stalled")
    // no result right after reset
    `ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid, "result valid after reset")
    // write data is zero unless memory is written
    `ASSERT_IMPL(a_wdata_zero, i_clk, i_rst_n, i_out_valid && !i_out_mem_write, i_out_mem_write_data == 8'd0, "write data without write")
endmodule

bind cpu8_arith_instruction_unit cpu8a_checker u_cpu8a_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_rsp.valid),
    .i_out_ready          (o_rsp.ready),
    .i_out_acc            (o_rsp.acc),
    .i_out_mem_address    (o_rsp.mem_address),
    .i_out_mem_write      (o_rsp.mem_write),
    .i_out_mem_write_data (o_rsp.mem_write_data)
);
`default_nettype wire

// File: dv/cpu8a_result_checker.sv
// Result checker: predicts each instruction's outcome and compares the result items.
module cpu8a_result_checker
    import cpu8a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cpu8a_in_if       i_req,
    cpu8a_out_if      i_rsp,
    output int        o_mismatches,
    output int        o_pending
);

    logic [7:0] gpr [NUM_REGS];
    logic [4:0] psw;
    t_result    results_due[$];
    int         fail_count = 0;

    assign o_mismatches = fail_count;

    // flag word order is S, Z, AC, P, CY (msb to lsb)
    function automatic logic [4:0] status_word(input logic [7:0] r, input logic ac,
                                               input logic cy);
        return {r[7], r == 8'd0, ac, ~^r, cy};
    endfunction

    function automatic int slot_of(input logic [2:0] sel);
        return (sel == SEL_A) ? int'(REG_A) : int'(sel);
    endfunction

    function automatic t_result execute_instr(input t_item it);
        t_result     res;
        logic [7:0]  a, src, op, r;
        logic [8:0]  wide;
        logic [4:0]  nib;
        logic        cin, ac;
        logic [15:0] hl, pv;
        logic [16:0] s17;
        int          hi;
        hl  = {gpr[REG_H], gpr[REG_L]};
        a   = gpr[REG_A];
        src = (it.reg_sel == SEL_MEM) ? it.mem_data : gpr[slot_of(it.reg_sel)];
        res = '0;
        res.mem_address = hl;
        case (it.req_type)
            OP_ADD, OP_ADC, OP_ADI, OP_ACI: begin
                op   = (it.req_type == OP_ADI || it.req_type == OP_ACI) ? it.imm : src;
                cin  = (it.req_type == OP_ADC || it.req_type == OP_ACI) ? psw[F_CY] : 1'b0;
                wide = {1'b0, a} + {1'b0, op} + {8'd0, cin};
                nib  = {1'b0, a[3:0]} + {1'b0, op[3:0]} + {4'd0, cin};
                gpr[REG_A] = wide[7:0];
                psw = status_word(wide[7:0], nib[4], wide[8]);
            end
            OP_SUB, OP_SBB, OP_SUI, OP_SBI: begin
                op   = (it.req_type == OP_SUI || it.req_type == OP_SBI) ? it.imm : src;
                cin  = (it.req_type == OP_SBB || it.req_type == OP_SBI) ? psw[F_CY] : 1'b0;
                // bit 8 / bit 4 of the wrapped difference is the borrow
                wide = {1'b0, a} - {1'b0, op} - {8'd0, cin};
                nib  = {1'b0, a[3:0]} - {1'b0, op[3:0]} - {4'd0, cin};
                gpr[REG_A] = wide[7:0];
                psw = status_word(wide[7:0], nib[4], wide[8]);
            end
            OP_INR, OP_DCR: begin
                if (it.req_type == OP_INR) begin
                    r  = src + 8'd1;
                    ac = (src[3:0] == 4'hF);
                end else begin
                    r  = src - 8'd1;
                    ac = (src[3:0] == 4'h0);
                end
                if (it.reg_sel == SEL_MEM) begin
                    res.mem_write      = 1'b1;
                    res.mem_write_data = r;
                end else begin
                    gpr[slot_of(it.reg_sel)] = r;
                end
                psw = status_word(r, ac, psw[F_CY]);
            end
            OP_INX, OP_DCX, OP_DAD: begin
                if (it.pair_sel != PAIR_NONE) begin
                    hi = 2 * it.pair_sel;
                    pv = {gpr[hi], gpr[hi+1]};
                    if (it.req_type == OP_DAD) begin
                        s17 = {1'b0, hl} + {1'b0, pv};
                        gpr[REG_H] = s17[15:8];
                        gpr[REG_L] = s17[7:0];
                        psw[F_CY]  = s17[16];
                    end else begin
                        pv = (it.req_type == OP_INX) ? pv + 16'd1 : pv - 16'd1;
                        gpr[hi]   = pv[15:8];
                        gpr[hi+1] = pv[7:0];
                    end
                end
            end
            OP_CMA: gpr[REG_A] = ~a;
            default: ;
        endcase
        res.acc   = gpr[REG_A];
        res.flags = psw;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_item   it;
        if (!i_rst_n) begin
            foreach (gpr[k]) gpr[k] = 8'd0;
            psw = '0;
            results_due.delete();
            o_pending <= 0;
        end else begin
            // retire before accept: a new item cannot produce a result this edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result acc", 16'(i_rsp.acc), 16'd0);
                end else begin
                    want = results_due.pop_front();
                    check_field("acc", 16'(i_rsp.acc), 16'(want.acc));
                    check_field("sign", 16'(i_rsp.sign_flag), 16'(want.flags[F_S]));
                    check_field("zero", 16'(i_rsp.zero_flag), 16'(want.flags[F_Z]));
                    check_field("aux", 16'(i_rsp.aux_flag), 16'(want.flags[F_AC]));
                    check_field("parity", 16'(i_rsp.parity_flag), 16'(want.flags[F_P]));
                    check_field("carry", 16'(i_rsp.carry_flag), 16'(want.flags[F_CY]));
                    check_field("mem_write", 16'(i_rsp.mem_write), 16'(want.mem_write));
                    check_field("mem_address", i_rsp.mem_address, want.mem_address);
                    check_field("mem_write_data", 16'(i_rsp.mem_write_data),
                                16'(want.mem_write_data));
                end
            end
            if (i_req.valid && i_req.ready) begin
                it.req_type = i_req.req_type;
                it.reg_sel  = i_req.reg_sel;
                it.pair_sel = i_req.pair_sel;
                it.imm      = i_req.imm;
                it.mem_data = i_req.mem_data;
                results_due.push_back(execute_instr(it));
            end
            o_pending <= results_due.size();
        end
    end

endmodule

// File: dv/tb_cpu8_arith_instruction_unit.sv
// Testbench top: instruction stimulus, result-side flow control and final verdict.
module tb_cpu8_arith_instruction_unit;
    import cpu8a_pkg::*;

    // req_type codes outside the instruction set; the block must treat them as no-ops
    localparam logic [3:0] OP_UNDEF_LO = 4'd14;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;

    // reg_sel codes for D and E (the package only names the slots it needs)
    localparam logic [2:0] SEL_D = 3'd2;
    localparam logic [2:0] SEL_E = 3'd3;

    // pair_sel codes
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLDOFF_CYCLES  = 60;   // long result-side stall to fill the pipe
    localparam int BURST_ITEMS     = 20;   // items offered during that stall

    logic i_clk;
    logic i_rst_n;

    cpu8a_in_if  req_ch ();
    cpu8a_out_if rsp_ch ();

    int mismatches;
    int pending;

    // idle odds in percent, read by the sender task and the ready process
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_req      = 1'b0;

    cpu8_arith_instruction_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    cpu8a_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Guard against a hung block or results that never arrive.
    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    // Result-side ready. A hold request from the stimulus makes this process
    // drop ready for a fixed stretch; otherwise ready follows the stall odds.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLDOFF_CYCLES) begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic t_item make_instr(input logic [3:0] op, input logic [2:0] sel,
                                         input logic [1:0] pair, input logic [7:0] imm,
                                         input logic [7:0] mem);
        t_item it;
        it.req_type = op;
        it.reg_sel  = sel;
        it.pair_sel = pair;
        it.imm      = imm;
        it.mem_data = mem;
        return it;
    endfunction

    // Mostly defined opcodes; a few undefined ones as noise. All other fields
    // are fully random, so pair_sel 3 and memory operands come up often.
    function automatic t_item random_instr();
        logic [3:0] op;
        if ($urandom_range(99) < 4)
            op = ($urandom_range(1) == 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
        else
            op = 4'($urandom_range(OP_CMA));
        return make_instr(op, 3'($urandom_range(7)), 2'($urandom_range(3)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    // Offer one item, with random idle cycles ahead of it, and hold it until
    // the block takes it. Ready is looked at as it stands at the edge itself.
    // Valid gets one assignment per time step.
    task automatic issue_instr(input t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= it.req_type;
        req_ch.reg_sel  <= it.reg_sel;
        req_ch.pair_sel <= it.pair_sel;
        req_ch.imm      <= it.imm;
        req_ch.mem_data <= it.mem_data;
        @(posedge i_clk iff req_ch.ready);
    endtask

    // Sender pause: drop valid and wait for every predicted result to come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        t_item opening_instrs[$];
        int    stall_plan [4][2];
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= '0;
        req_ch.reg_sel  <= '0;
        req_ch.pair_sel <= '0;
        req_ch.imm      <= '0;
        req_ch.mem_data <= '0;

        // sender idle / receiver stall odds per phase
        stall_plan = '{'{0, 0}, '{46, 0}, '{0, 46}, '{23, 23}};

        // Directed opening: carry chains through ACI/ADC, nibble carry on INR
        // of F and borrow on DCR of 0, memory INR/DCR, A as INR target,
        // DAD of DE and of HL, pair 3 no-ops, CMA and the two undefined opcodes.
        opening_instrs.push_back(make_instr(OP_ADI, REG_B,   PAIR_BC,   8'hFF, 8'h00));
        opening_instrs.push_back(make_instr(OP_ACI, REG_B,   PAIR_BC,   8'h01, 8'h00));
        opening_instrs.push_back(make_instr(OP_ACI, REG_C,   PAIR_BC,   8'hFF, 8'h00));
        opening_instrs.push_back(make_instr(OP_ADC, SEL_MEM, PAIR_BC,   8'h00, 8'h80));
        opening_instrs.push_back(make_instr(OP_INR, REG_B,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_INR, SEL_MEM, PAIR_BC,   8'h00, 8'hFF));
        opening_instrs.push_back(make_instr(OP_DCR, SEL_MEM, PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_INR, SEL_A,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_DCR, REG_C,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_DCR, SEL_E,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_SUB, REG_B,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_SBB, SEL_MEM, PAIR_BC,   8'h00, 8'hFF));
        opening_instrs.push_back(make_instr(OP_SUI, REG_B,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_SBI, REG_B,   PAIR_BC,   8'hFF, 8'h00));
        opening_instrs.push_back(make_instr(OP_SUB, SEL_A,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_INX, REG_B,   PAIR_HL,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_DCX, REG_B,   PAIR_DE,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_DAD, REG_B,   PAIR_DE,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_DAD, REG_B,   PAIR_HL,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_INX, REG_B,   PAIR_NONE, 8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_DCX, REG_B,   PAIR_NONE, 8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_DAD, REG_B,   PAIR_NONE, 8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_CMA, REG_B,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_ADD, REG_H,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_ADD, SEL_D,   PAIR_BC,   8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_UNDEF_LO, REG_L, PAIR_BC, 8'h00, 8'h00));
        opening_instrs.push_back(make_instr(OP_UNDEF_HI, SEL_A, PAIR_NONE, 8'hFF, 8'hFF));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct  = stall_plan[phase][0];
            snk_stall_pct = stall_plan[phase][1];
            if (phase == 0) begin
                foreach (opening_instrs[k]) issue_instr(opening_instrs[k]);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Back-pressure burst: results held off while the sender keeps
                // offering, so the block fills and drops its input ready.
                if ((phase == 0 || phase == 3) && n == ITEMS_PER_PHASE / 2) begin
                    hold_req = 1'b1;
                    for (int b = 0; b < BURST_ITEMS; b++) issue_instr(random_instr());
                end
                issue_instr(random_instr());
            end
            drain_results();
        end

        // Let any late or extra result show up before the verdict.
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/cpu8a_pkg.sv
hdl/cpu8a_if.sv
hdl/cpu8a_ram.sv
hdl/cpu8a_exec.sv
hdl/cpu8_arith_instruction_unit.sv
hdl/cpu8a_checker.sv
dv/cpu8a_result_checker.sv
dv/tb_cpu8_arith_instruction_unit.sv
